// File: sv/vpw_pkg.sv
// ----------------------------------------------------------------------------
// vpw_pkg: shared types and constants for the vertex projection pipeline
// Fixed point is signed Q16.16 in 32 bits throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpw_pkg;

  // number formats
  localparam int COORD_W = 32;
  localparam int FRAC = 16;
  localparam int PROD_W = 2 * COORD_W;
  localparam int RND_W = PROD_W - FRAC;
  localparam int SUM_W = RND_W + 2;

  // divider shape: quotient bits per stage times stages covers the word
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = COORD_W / DIV_STEP;

  // configuration port
  localparam int VP_W = 16;
  localparam int VP_SIZE_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd3;

  localparam logic [VP_SIZE_W-1:0] VP_WIDTH_RST = 15'd640;
  localparam logic [VP_SIZE_W-1:0] VP_HEIGHT_RST = 15'd480;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0] rnd_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam coord_t ONE_Q = coord_t'(1 << FRAC);
  localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  // rounding bias, halves away from zero
  localparam prod_t RND_BIAS_POS = prod_t'(1 << (FRAC - 1));
  localparam prod_t RND_BIAS_NEG = prod_t'((1 << (FRAC - 1)) - 1);

  typedef struct packed {
    logic        kind;
    logic        matrix_select;
    logic [3:0]  coeff_index;
    coord_t      coeff_value;
    coord_t      obj_x;
    coord_t      obj_y;
    coord_t      obj_z;
  } in_word_t;

  typedef struct packed {
    logic   ok;
    coord_t win_x;
    coord_t win_y;
    coord_t win_z;
  } out_word_t;

  // control that travels with a word through the transform stages
  typedef struct packed {
    logic       vld;
    logic       load;
    logic       sel;
    logic [3:0] idx;
    coord_t     val;
  } tag_t;

  typedef struct packed {
    logic signed [VP_W-1:0] vp_x;
    logic signed [VP_W-1:0] vp_y;
    logic [VP_SIZE_W-1:0]   vp_w;
    logic [VP_SIZE_W-1:0]   vp_h;
  } view_cfg_t;

  // clamp a wide sum to the coordinate range
  function automatic coord_t sat_coord(input sum_t v);
    if (v > sum_t'(CMAX)) begin
      return CMAX;
    end else if (v < sum_t'(CMIN)) begin
      return CMIN;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

// File: sv/vpw_xform.sv
// ----------------------------------------------------------------------------
// vpw_xform: 4x4 matrix times vector, three register stages
// Multiply, round each product, then sum and saturate each row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpw_xform (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  vpw_pkg::tag_t     tag_in,
  input  vpw_pkg::coord_t   vec_in [4],
  input  vpw_pkg::coord_t   mat [16],
  output vpw_pkg::tag_t     tag_out,
  output vpw_pkg::coord_t   vec_out [4]
);

  vpw_pkg::prod_t  prod [16];
  vpw_pkg::rnd_t   rnd [16];
  vpw_pkg::prod_t  prod_next [16];
  vpw_pkg::rnd_t   rnd_next [16];
  vpw_pkg::coord_t sum_next [4];
  vpw_pkg::tag_t   tag1;
  vpw_pkg::tag_t   tag2;

  // column-major products, coefficient k meets vector element k/4
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      prod_next[k] = vpw_pkg::prod_t'(mat[k]) * vpw_pkg::prod_t'(vec_in[k >> 2]);
    end
  end

  // round each product to the fraction width
  always_comb begin
    vpw_pkg::prod_t tmp;
    tmp = '0;
    for (int k = 0; k < 16; k++) begin
      tmp = prod[k] + (prod[k][vpw_pkg::PROD_W-1] ? vpw_pkg::RND_BIAS_NEG
                                                 : vpw_pkg::RND_BIAS_POS);
      rnd_next[k] = tmp[vpw_pkg::PROD_W-1:vpw_pkg::FRAC];
    end
  end

  // row sums with saturation
  always_comb begin
    vpw_pkg::sum_t s;
    s = '0;
    for (int r = 0; r < 4; r++) begin
      s = vpw_pkg::sum_t'(rnd[r]) + vpw_pkg::sum_t'(rnd[4 + r]) +
          vpw_pkg::sum_t'(rnd[8 + r]) + vpw_pkg::sum_t'(rnd[12 + r]);
      sum_next[r] = vpw_pkg::sat_coord(s);
    end
  end

  // control stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
      tag2.vld <= 1'b0;
      tag_out.vld <= 1'b0;
    end else if (adv) begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag_out <= tag2;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
      rnd <= rnd_next;
      vec_out <= sum_next;
    end
  end

endmodule

// File: sv/vpw_div.sv
// ----------------------------------------------------------------------------
// vpw_div: pipelined divide of three numerators by one shared clip w
// Restoring division, four quotient bits per stage, rounded and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpw_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              vld_in,
  input  vpw_pkg::coord_t   num [3],
  input  vpw_pkg::coord_t   den,
  output logic              vld_out,
  output logic              ok_out,
  output vpw_pkg::coord_t   ndc [3]
);

  localparam int N = vpw_pkg::DIV_STAGES;
  localparam int W = vpw_pkg::COORD_W;
  localparam int F = vpw_pkg::FRAC;

  // stage registers, index 0 is the prepared operand stage
  logic         vld_s  [N+1];
  logic         zw_s   [N+1];
  logic [W-1:0] d_s    [N+1];
  logic [W-1:0] rem_s  [N+1][3];
  logic [W-1:0] q_s    [N+1][3];
  logic [W-1:0] low_s  [N+1][3];
  logic         neg_s  [N+1][3];
  logic         over_s [N+1][3];

  logic [W-1:0] rem_n [N][3];
  logic [W-1:0] q_n   [N][3];
  logic [W-1:0] low_n [N][3];

  logic [W-1:0] d_p;
  logic [W-1:0] rem_p [3];
  logic [W-1:0] low_p [3];
  logic         neg_p [3];
  logic         over_p [3];
  vpw_pkg::coord_t ndc_next [3];

  // operand magnitudes and early overflow check
  always_comb begin
    logic [W-1:0] a;
    a = '0;
    d_p = den[W-1] ? W'(-den) : W'(den);
    for (int l = 0; l < 3; l++) begin
      a = num[l][W-1] ? W'(-num[l]) : W'(num[l]);
      rem_p[l] = {{F{1'b0}}, a[W-1:F]};
      low_p[l] = {a[F-1:0], {(W-F){1'b0}}};
      neg_p[l] = num[l][W-1] ^ den[W-1];
      over_p[l] = {{F{1'b0}}, a[W-1:F]} >= d_p;
    end
  end

  // quotient bit steps per stage
  always_comb begin
    logic [W:0] t;
    t = '0;
    for (int s = 0; s < N; s++) begin
      for (int l = 0; l < 3; l++) begin
        rem_n[s][l] = rem_s[s][l];
        q_n[s][l] = q_s[s][l];
        low_n[s][l] = low_s[s][l];
        for (int i = 0; i < vpw_pkg::DIV_STEP; i++) begin
          t = {rem_n[s][l], low_n[s][l][W-1]};
          low_n[s][l] = {low_n[s][l][W-2:0], 1'b0};
          if (t >= {1'b0, d_s[s]}) begin
            rem_n[s][l] = W'(t - {1'b0, d_s[s]});
            q_n[s][l] = {q_n[s][l][W-2:0], 1'b1};
          end else begin
            rem_n[s][l] = t[W-1:0];
            q_n[s][l] = {q_n[s][l][W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round to nearest, apply sign, saturate
  always_comb begin
    logic       up;
    logic [W:0] qr;
    logic       big;
    up = 1'b0;
    qr = '0;
    big = 1'b0;
    for (int l = 0; l < 3; l++) begin
      up = {rem_s[N][l], 1'b0} >= {1'b0, d_s[N]};
      qr = {1'b0, q_s[N][l]} + (W+1)'(up);
      big = over_s[N][l] || qr[W] || qr[W-1];
      if (big) begin
        ndc_next[l] = neg_s[N][l] ? vpw_pkg::CMIN : vpw_pkg::CMAX;
      end else if (neg_s[N][l]) begin
        ndc_next[l] = -vpw_pkg::coord_t'(qr[W-1:0]);
      end else begin
        ndc_next[l] = vpw_pkg::coord_t'(qr[W-1:0]);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= N; s++) begin
        vld_s[s] <= 1'b0;
      end
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_s[0] <= vld_in;
      for (int s = 0; s < N; s++) begin
        vld_s[s+1] <= vld_s[s];
      end
      vld_out <= vld_s[N];
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (adv) begin
      d_s[0] <= d_p;
      zw_s[0] <= (den == '0);
      rem_s[0] <= rem_p;
      low_s[0] <= low_p;
      neg_s[0] <= neg_p;
      over_s[0] <= over_p;
      for (int l = 0; l < 3; l++) begin
        q_s[0][l] <= '0;
      end
      for (int s = 0; s < N; s++) begin
        d_s[s+1] <= d_s[s];
        zw_s[s+1] <= zw_s[s];
        rem_s[s+1] <= rem_n[s];
        q_s[s+1] <= q_n[s];
        low_s[s+1] <= low_n[s];
        neg_s[s+1] <= neg_s[s];
        over_s[s+1] <= over_s[s];
      end
      ok_out <= !zw_s[N];
      ndc <= ndc_next;
    end
  end

endmodule

// File: sv/vpw_view.sv
// ----------------------------------------------------------------------------
// vpw_view: viewport mapping of the normalized coordinates
// Shift to [0,2], scale by viewport size, halve, add origin, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpw_view (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               vld_in,
  input  logic               ok_in,
  input  vpw_pkg::coord_t    ndc [3],
  input  vpw_pkg::view_cfg_t cfg,
  output logic               out_valid,
  output vpw_pkg::out_word_t out_word
);

  localparam int W = vpw_pkg::COORD_W;
  localparam int PW = W + 1 + vpw_pkg::VP_SIZE_W;

  logic          vld1, vld2;
  logic          ok1, ok2;
  logic          neg1 [3];
  logic          neg2 [3];
  logic [W:0]    ms1 [3];
  logic [PW-1:0] p2 [3];

  logic [W:0]    ms_next [3];
  logic          neg_next [3];
  logic [PW-1:0] p_next [3];
  vpw_pkg::coord_t win_next [3];

  // add one and take the magnitude
  always_comb begin
    logic signed [W:0] s;
    s = '0;
    for (int l = 0; l < 3; l++) begin
      s = (W+1)'(ndc[l]) + (W+1)'(vpw_pkg::ONE_Q);
      neg_next[l] = s[W];
      ms_next[l] = s[W] ? (W+1)'(-s) : (W+1)'(s);
    end
  end

  // scale by viewport size, depth keeps scale one
  always_comb begin
    p_next[0] = PW'(ms1[0]) * PW'(cfg.vp_w);
    p_next[1] = PW'(ms1[1]) * PW'(cfg.vp_h);
    p_next[2] = PW'(ms1[2]);
  end

  // halve away from zero, add origin, saturate
  always_comb begin
    logic [PW-1:0] h;
    vpw_pkg::sum_t v;
    vpw_pkg::sum_t org;
    h = '0;
    v = '0;
    org = '0;
    for (int l = 0; l < 3; l++) begin
      h = (p2[l] >> 1) + PW'(p2[l][0]);
      v = neg2[l] ? -vpw_pkg::sum_t'(h) : vpw_pkg::sum_t'(h);
      if (l == 0) begin
        org = vpw_pkg::sum_t'(cfg.vp_x) <<< vpw_pkg::FRAC;
      end else if (l == 1) begin
        org = vpw_pkg::sum_t'(cfg.vp_y) <<< vpw_pkg::FRAC;
      end else begin
        org = '0;
      end
      win_next[l] = ok2 ? vpw_pkg::sat_coord(org + v) : '0;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld1 <= vld_in;
      vld2 <= vld1;
      out_valid <= vld2;
    end
  end

  // data chain and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      ok1 <= ok_in;
      ms1 <= ms_next;
      neg1 <= neg_next;
      ok2 <= ok1;
      p2 <= p_next;
      neg2 <= neg1;
      out_word.ok <= ok2;
      out_word.win_x <= win_next[0];
      out_word.win_y <= win_next[1];
      out_word.win_z <= win_next[2];
    end
  end

endmodule

// File: sv/vertex_project_to_window.sv
// Throughput: one word per cycle while the pipeline advances; loads enter at the same rate and give no result.
// The whole pipeline moves while the output register is empty or being taken.
// Reset: synchronous, clears valid bits, sets both matrices to identity and
// the viewport to origin 0,0 with size 640 by 480.
// ----------------------------------------------------------------------------
// vertex_project_to_window: fixed-point projection of points to the window
// Modelview and projection transforms, perspective divide, viewport mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_project_to_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vpw_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vpw_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [vpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vpw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic               adv;
  vpw_pkg::coord_t    mv [16];
  vpw_pkg::coord_t    pj [16];
  vpw_pkg::view_cfg_t cfg;
  vpw_pkg::tag_t      tag0;
  vpw_pkg::tag_t      tag1;
  vpw_pkg::tag_t      tag2;
  vpw_pkg::coord_t    obj [4];
  vpw_pkg::coord_t    eye [4];
  vpw_pkg::coord_t    clip [4];
  vpw_pkg::coord_t    num [3];
  vpw_pkg::coord_t    ndc [3];
  logic               div_vld;
  logic               div_ok;

  // global advance, output register parts the sides
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // incoming word as tag and vector
  always_comb begin
    tag0.vld = in_valid;
    tag0.load = !in_data.kind;
    tag0.sel = in_data.matrix_select;
    tag0.idx = in_data.coeff_index;
    tag0.val = in_data.coeff_value;
    obj[0] = in_data.obj_x;
    obj[1] = in_data.obj_y;
    obj[2] = in_data.obj_z;
    obj[3] = vpw_pkg::ONE_Q;
  end

  // modelview loads land at the input, projection loads where it is read
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        mv[k] <= ((k >> 2) == (k & 3)) ? vpw_pkg::ONE_Q : '0;
        pj[k] <= ((k >> 2) == (k & 3)) ? vpw_pkg::ONE_Q : '0;
      end
    end else begin
      if (in_valid && in_ready && !in_data.kind && !in_data.matrix_select) begin
        mv[in_data.coeff_index] <= in_data.coeff_value;
      end
      if (adv && tag1.vld && tag1.load && tag1.sel) begin
        pj[tag1.idx] <= tag1.val;
      end
    end
  end

  // viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vp_x <= '0;
      cfg.vp_y <= '0;
      cfg.vp_w <= vpw_pkg::VP_WIDTH_RST;
      cfg.vp_h <= vpw_pkg::VP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vpw_pkg::REG_VIEWPORT_X: cfg.vp_x <= cfg_data;
        vpw_pkg::REG_VIEWPORT_Y: cfg.vp_y <= cfg_data;
        vpw_pkg::REG_VIEWPORT_WIDTH: cfg.vp_w <= cfg_data[vpw_pkg::VP_SIZE_W-1:0];
        vpw_pkg::REG_VIEWPORT_HEIGHT: cfg.vp_h <= cfg_data[vpw_pkg::VP_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // object to eye
  vpw_xform u_mv (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag0),
    .vec_in  (obj),
    .mat     (mv),
    .tag_out (tag1),
    .vec_out (eye)
  );

  // eye to clip
  vpw_xform u_pj (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag1),
    .vec_in  (eye),
    .mat     (pj),
    .tag_out (tag2),
    .vec_out (clip)
  );

  assign num[0] = clip[0];
  assign num[1] = clip[1];
  assign num[2] = clip[2];

  // perspective divide, project words only
  vpw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (tag2.vld && !tag2.load),
    .num     (num),
    .den     (clip[3]),
    .vld_out (div_vld),
    .ok_out  (div_ok),
    .ndc     (ndc)
  );

  // viewport mapping and output register
  vpw_view u_view (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .vld_in    (div_vld),
    .ok_in     (div_ok),
    .ndc       (ndc),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

`ifndef SYNTHESIS
  // a held result word blocks new input
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // zero clip w gives all-zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |->
      out_data.win_x == '0 && out_data.win_y == '0 && out_data.win_z == '0)
    else $error("nonzero coordinates with ok low");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word right after reset");
`endif

endmodule
